// ===== src/dcsma_pkg.sv =====
package dcsma_pkg;

	// field widths
	localparam int unsigned SAMPLE_W = 12;
	localparam int unsigned MV_W     = 12;

	// scaling constants: mv = code * FULL_SCALE_MV / FULL_SCALE_CODE
	localparam int unsigned FULL_SCALE_CODE = 4095;
	localparam int unsigned FULL_SCALE_MV   = 3300;

	// width of code * FULL_SCALE_MV
	localparam int unsigned PROD_W = 24;

endpackage

// ===== src/dcsma_if.sv =====
interface dcsma_in_if;
	logic                             valid;
	logic                             ready;
	logic [dcsma_pkg::SAMPLE_W-1:0]   sample_ch1;
	logic [dcsma_pkg::SAMPLE_W-1:0]   sample_ch2;

	modport source (output valid, output sample_ch1, output sample_ch2, input ready);
	modport sink   (input valid, input sample_ch1, input sample_ch2, output ready);
endinterface

interface dcsma_out_if;
	logic                         valid;
	logic                         ready;
	logic [dcsma_pkg::MV_W-1:0]   millivolts_ch1;
	logic [dcsma_pkg::MV_W-1:0]   millivolts_ch2;
	logic [dcsma_pkg::MV_W-1:0]   average_ch1;
	logic [dcsma_pkg::MV_W-1:0]   average_ch2;
	logic                         window_full;

	modport source (output valid, output millivolts_ch1, output millivolts_ch2,
		output average_ch1, output average_ch2, output window_full, input ready);
	modport sink   (input valid, input millivolts_ch1, input millivolts_ch2,
		input average_ch1, input average_ch2, input window_full, output ready);
endinterface

// ===== src/dual_channel_adc_scale_moving_average_unit.sv =====
// Two-channel ADC scaler with a boxcar moving average.
// sample_in takes a pair of 12-bit conversions per request; result_out gives
// both values in millivolts (code*3300/4095, truncated), the truncated mean of
// the last WINDOW_LENGTH millivolt values of each channel, and window_full.
// Pairs that arrive before the first pair with a nonzero second sample are
// consumed and dropped; that pair and every later pair give one result.
// Throughput: one pair per cycle while result_out is not stalled, set by the
// four registered stages (input, scale, window update, average).
// Reset closes the gate, empties the window (ring contents are ignored until
// rewritten, tracked by the slot pointer and fill flag) and clears the sums.
// When result_out stalls, the result holds steady and the stages behind it
// keep taking pairs until all four are occupied; then sample_in.ready drops.
module dual_channel_adc_scale_moving_average_unit #(
	parameter int unsigned WINDOW_LENGTH = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	dcsma_in_if.sink     sample_in,
	dcsma_out_if.source  result_out
);
	import dcsma_pkg::*;

	localparam int unsigned SUM_W = $clog2(WINDOW_LENGTH * FULL_SCALE_MV + 1);

	logic                gate_q;
	logic                accept;
	logic                pass;
	logic                v1_s1, v2_s2, v3_s3, v4_s4;
	logic                rdy1, rdy2, rdy3, rdy4;
	logic [SAMPLE_W-1:0] ch1_s1, ch2_s1;
	logic [MV_W-1:0]     mv1_s2, mv2_s2;
	logic [MV_W-1:0]     mv1_s3, mv2_s3;
	logic [SUM_W-1:0]    sum1_s3, sum2_s3;
	logic                full_s3;
	logic [MV_W-1:0]     mv1_s4, mv2_s4;
	logic [MV_W-1:0]     avg1_s4, avg2_s4;
	logic                full_s4;

	// stage handshake, each stage frees as its successor takes its item
	always_comb begin
		rdy4   = !v4_s4 || result_out.ready;
		rdy3   = !v3_s3 || rdy4;
		rdy2   = !v2_s2 || rdy3;
		rdy1   = !v1_s1 || rdy2;
		accept = sample_in.valid && rdy1;
		pass   = gate_q || (sample_in.sample_ch2 != '0);
	end

	assign sample_in.ready = rdy1;

	// start gate and stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_q <= 1'b0;
			v1_s1  <= 1'b0;
			v2_s2  <= 1'b0;
			v3_s3  <= 1'b0;
			v4_s4  <= 1'b0;
		end else begin
			if (accept && pass) begin
				gate_q <= 1'b1;
			end
			if (rdy1) begin
				v1_s1 <= accept && pass;
			end
			if (rdy2) begin
				v2_s2 <= v1_s1;
			end
			if (rdy3) begin
				v3_s3 <= v2_s2;
			end
			if (rdy4) begin
				v4_s4 <= v3_s3;
			end
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (accept) begin
			ch1_s1 <= sample_in.sample_ch1;
			ch2_s1 <= sample_in.sample_ch2;
		end
	end

	// millivolt scaling
	dcsma_scale u_scale_ch1 (
		.clk   (clk),
		.load  (rdy2),
		.code  (ch1_s1),
		.mv_s2 (mv1_s2)
	);

	dcsma_scale u_scale_ch2 (
		.clk   (clk),
		.load  (rdy2),
		.code  (ch2_s1),
		.mv_s2 (mv2_s2)
	);

	// ring update and running sums
	dcsma_window #(
		.WINDOW_LENGTH (WINDOW_LENGTH)
	) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (rdy3),
		.commit  (v2_s2 && rdy3),
		.mv1     (mv1_s2),
		.mv2     (mv2_s2),
		.mv1_s3  (mv1_s3),
		.mv2_s3  (mv2_s3),
		.sum1_s3 (sum1_s3),
		.sum2_s3 (sum2_s3),
		.full_s3 (full_s3)
	);

	// window means
	dcsma_average #(
		.WINDOW_LENGTH (WINDOW_LENGTH)
	) u_avg_ch1 (
		.clk   (clk),
		.load  (rdy4),
		.sum   (sum1_s3),
		.avg_q (avg1_s4)
	);

	dcsma_average #(
		.WINDOW_LENGTH (WINDOW_LENGTH)
	) u_avg_ch2 (
		.clk   (clk),
		.load  (rdy4),
		.sum   (sum2_s3),
		.avg_q (avg2_s4)
	);

	// output register
	always_ff @(posedge clk) begin
		if (rdy4) begin
			mv1_s4  <= mv1_s3;
			mv2_s4  <= mv2_s3;
			full_s4 <= full_s3;
		end
	end

	assign result_out.valid          = v4_s4;
	assign result_out.millivolts_ch1 = mv1_s4;
	assign result_out.millivolts_ch2 = mv2_s4;
	assign result_out.average_ch1    = avg1_s4;
	assign result_out.average_ch2    = avg2_s4;
	assign result_out.window_full    = full_s4;

endmodule

// ===== src/dcsma_scale.sv =====
module dcsma_scale (
	input  logic                            clk,
	input  logic                            load,
	input  logic [dcsma_pkg::SAMPLE_W-1:0]  code,
	output logic [dcsma_pkg::MV_W-1:0]      mv_s2
);
	import dcsma_pkg::*;

	logic [PROD_W-1:0]   prod;
	logic [MV_W-1:0]     q_est;
	logic [SAMPLE_W:0]   rem;
	logic [MV_W-1:0]     mv;

	// code * 3300, then divide by 4095 as prod/4096 plus one correction step
	// prod = 4095*q_est + (low bits + q_est), and that remainder stays below 2*4095
	always_comb begin
		prod  = PROD_W'(code) * PROD_W'(FULL_SCALE_MV);
		q_est = MV_W'(prod[PROD_W-1:SAMPLE_W]);
		rem   = {1'b0, prod[SAMPLE_W-1:0]} + (SAMPLE_W+1)'(q_est);
		mv    = q_est + MV_W'(rem >= (SAMPLE_W+1)'(FULL_SCALE_CODE));
	end

	// scaled value register
	always_ff @(posedge clk) begin
		if (load) begin
			mv_s2 <= mv;
		end
	end

endmodule

// ===== src/dcsma_window.sv =====
module dcsma_window #(
	parameter int unsigned WINDOW_LENGTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  logic                          commit,
	input  logic [dcsma_pkg::MV_W-1:0]    mv1,
	input  logic [dcsma_pkg::MV_W-1:0]    mv2,
	output logic [dcsma_pkg::MV_W-1:0]    mv1_s3,
	output logic [dcsma_pkg::MV_W-1:0]    mv2_s3,
	output logic [$clog2(WINDOW_LENGTH*dcsma_pkg::FULL_SCALE_MV+1)-1:0] sum1_s3,
	output logic [$clog2(WINDOW_LENGTH*dcsma_pkg::FULL_SCALE_MV+1)-1:0] sum2_s3,
	output logic                          full_s3
);
	import dcsma_pkg::*;

	localparam int unsigned SUM_W  = $clog2(WINDOW_LENGTH * FULL_SCALE_MV + 1);
	localparam int unsigned IDX_W  = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
	localparam int unsigned WORD_W = 2 * MV_W;

	logic [WORD_W-1:0] ring_mem [WINDOW_LENGTH];
	logic [WORD_W-1:0] rd_q;
	logic [WORD_W-1:0] wd_q;
	logic              byp_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  idx_nxt;
	logic              filled_q;
	logic [SUM_W-1:0]  sum1_q;
	logic [SUM_W-1:0]  sum2_q;
	logic [SUM_W-1:0]  sum1_nxt;
	logic [SUM_W-1:0]  sum2_nxt;
	logic              last;
	logic [WORD_W-1:0] wdata;
	logic [WORD_W-1:0] old_word;

	// slot pointer; the slot being replaced is written before only once the ring has wrapped
	always_comb begin
		last    = (idx_q == IDX_W'(WINDOW_LENGTH - 1));
		idx_nxt = idx_q;
		if (commit) begin
			idx_nxt = last ? '0 : idx_q + IDX_W'(1);
		end
		wdata = {mv2, mv1};
		if (!filled_q) begin
			old_word = '0;
		end else if (byp_q) begin
			old_word = wd_q;
		end else begin
			old_word = rd_q;
		end
		sum1_nxt = sum1_q - SUM_W'(old_word[MV_W-1:0]) + SUM_W'(mv1);
		sum2_nxt = sum2_q - SUM_W'(old_word[WORD_W-1:MV_W]) + SUM_W'(mv2);
	end

	// ring memory, read one request ahead at the next slot
	always_ff @(posedge clk) begin
		if (commit) begin
			ring_mem[idx_q] <= wdata;
		end
		rd_q <= ring_mem[idx_nxt];
		wd_q <= wdata;
	end

	// read-during-write bypass, only hit with a one-entry window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else begin
			byp_q <= commit && (idx_nxt == idx_q);
		end
	end

	// pointer, fill state and running sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			filled_q <= 1'b0;
			sum1_q   <= '0;
			sum2_q   <= '0;
		end else if (commit) begin
			idx_q    <= idx_nxt;
			filled_q <= filled_q | last;
			sum1_q   <= sum1_nxt;
			sum2_q   <= sum2_nxt;
		end
	end

	// stage 3 payload
	always_ff @(posedge clk) begin
		if (load) begin
			mv1_s3  <= mv1;
			mv2_s3  <= mv2;
			sum1_s3 <= sum1_nxt;
			sum2_s3 <= sum2_nxt;
			full_s3 <= filled_q | last;
		end
	end

endmodule

// ===== src/dcsma_average.sv =====
module dcsma_average #(
	parameter int unsigned WINDOW_LENGTH = 16
) (
	input  logic                        clk,
	input  logic                        load,
	input  logic [$clog2(WINDOW_LENGTH*dcsma_pkg::FULL_SCALE_MV+1)-1:0] sum,
	output logic [dcsma_pkg::MV_W-1:0]  avg_q
);
	import dcsma_pkg::*;

	localparam int unsigned SUM_W   = $clog2(WINDOW_LENGTH * FULL_SCALE_MV + 1);
	localparam int unsigned LOG_W   = $clog2(WINDOW_LENGTH);
	localparam int unsigned SHIFT   = SUM_W + LOG_W;
	localparam int unsigned RECIP_W = SUM_W + 2;
	localparam longint unsigned RECIP =
		((64'd1 << SHIFT) + WINDOW_LENGTH - 1) / WINDOW_LENGTH;

	logic [SUM_W+RECIP_W-1:0] prod;

	// sum / WINDOW_LENGTH as multiply by rounded-up reciprocal, exact over the sum range
	always_comb begin
		prod = (SUM_W+RECIP_W)'(sum) * (SUM_W+RECIP_W)'(RECIP_W'(RECIP));
	end

	// result register
	always_ff @(posedge clk) begin
		if (load) begin
			avg_q <= prod[SHIFT +: MV_W];
		end
	end

endmodule
